// ===== design/assert_macros.svh =====
// Assertion macros shared by the capsule table RTL.
// Both expect signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CPT_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("capsule table check failed");

// Antecedent at one edge implies the consequent at the next edge.
`define CPT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("capsule table check failed");

`endif

// ===== design/cpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Types and constants of the capsule push-out table.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int CPT_ENTRIES = 32;

  // operation codes
  localparam logic [1:0] OP_REG    = 2'd0;
  localparam logic [1:0] OP_APPLY  = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;

  // 0.001 in raw Q16.16 units: per component and squared
  localparam logic [32:0] MATCH_COMP = 33'd66;
  localparam logic [14:0] MATCH_D2   = 15'd4295;
  // shortest segment, squared raw length
  localparam logic [65:0] SEG_MIN_D2 = 66'd43;
  localparam logic [15:0] HIT_MAX    = 16'hFFFF;
  localparam logic [15:0] AGE_RESET  = 16'd60;

  // divide / square root unit widths
  localparam int DS_NW    = 98;
  localparam int DS_DW    = 66;
  localparam int DS_STEPS = 32;

  // one table row
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [30:0]        rad;
    logic [31:0]        stamp;
    logic [15:0]        hits;
  } cpt_row_t;

  // magnitude of a 33-bit signed value
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

// ===== design/cpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cpt_divsqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_divsqrt
// Shared restoring divider and integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module cpt_divsqrt import cpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             sqrt_mode,
  input  logic [DS_NW-1:0] num,
  input  logic [DS_DW-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [31:0]      result
);

  logic [DS_NW-1:0] rem;
  logic [DS_NW-1:0] dsh;     // shifted divisor, or root so far
  logic [63:0]      bitv;    // root trial bit
  logic [31:0]      quo;
  logic [4:0]       cnt;
  logic             mode;
  logic [DS_NW-1:0] cand;
  logic             ge;

  // one compare and subtract per step
  assign cand   = mode ? (dsh + DS_NW'(bitv)) : dsh;
  assign ge     = (rem >= cand);
  assign result = mode ? dsh[31:0] : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        mode <= sqrt_mode;
        dsh  <= sqrt_mode ? '0 : (DS_NW'(den) << (DS_STEPS - 1));
        bitv <= 64'h4000_0000_0000_0000;
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - cand;
        end
        quo  <= {quo[30:0], ge};
        dsh  <= mode ? ((dsh >> 1) + (ge ? DS_NW'(bitv) : '0)) : (dsh >> 1);
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(DS_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/capsule_pushout_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_pushout_table
// Table of capsule pushers: register, apply to a point, expire old entries.
// ----------------------------------------------------------------------------
// One word at a time. A register or expire word walks the stored entries,
// each through the loop, read, dispatch and next states. An apply word walks
// every entry through one multiplier and the shared 32-step divide / square
// root unit: one divide for the segment parameter, then one square root and
// three divides for the push, plus the multiply steps; an entry whose capsule
// is missed early skips the later ones. The result sits in an output register
// so the next word can be taken while it waits. Entry storage is one RAM of
// ENTRIES rows; the table starts empty after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module capsule_pushout_table import cpt_pkg::*; #(
  parameter int ENTRIES = CPT_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] p_x,
  input  logic signed [31:0] p_y,
  input  logic signed [31:0] p_z,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic signed [31:0] q_z,
  input  logic [30:0]        push_radius,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               moved,
  output logic [15:0]        hit_count
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOOP   = 5'd1;
  localparam logic [4:0] S_RD     = 5'd2;
  localparam logic [4:0] S_DISP   = 5'd3;
  localparam logic [4:0] S_APP_M  = 5'd4;
  localparam logic [4:0] S_APP_A  = 5'd5;
  localparam logic [4:0] S_SEG    = 5'd6;
  localparam logic [4:0] S_TWAIT  = 5'd7;
  localparam logic [4:0] S_CM     = 5'd8;
  localparam logic [4:0] S_CA     = 5'd9;
  localparam logic [4:0] S_DCHK   = 5'd10;
  localparam logic [4:0] S_DM     = 5'd11;
  localparam logic [4:0] S_DA     = 5'd12;
  localparam logic [4:0] S_LEN    = 5'd13;
  localparam logic [4:0] S_LWAIT  = 5'd14;
  localparam logic [4:0] S_PM     = 5'd15;
  localparam logic [4:0] S_PDIV   = 5'd16;
  localparam logic [4:0] S_PWAIT  = 5'd17;
  localparam logic [4:0] S_HIT    = 5'd18;
  localparam logic [4:0] S_NEXT   = 5'd19;
  localparam logic [4:0] S_APPEND = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;

  // control
  logic [4:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [2:0]    k;
  logic [15:0]   max_age;

  // latched word
  logic [1:0]         op;
  logic signed [31:0] p [3];
  logic signed [31:0] q [3];
  logic [30:0]        rad_in;
  logic [31:0]        now_r;

  // per-entry datapath
  logic [65:0]        prod;
  logic [65:0]        ab2;
  logic [65:0]        pos;
  logic [65:0]        neg;
  logic [65:0]        d2;
  logic [65:0]        rr;
  logic [31:0]        t;
  logic [31:0]        len;
  logic signed [33:0] cen [3];
  logic [30:0]        dmag [3];
  logic               dneg [3];
  logic               mvd;
  logic [15:0]        hit_r;

  // RAM ports
  cpt_row_t      row;
  cpt_row_t      wrow;
  logic          we;
  logic [IW-1:0] waddr;

  // shared unit ports
  logic             ds_start;
  logic             ds_sqrt;
  logic [DS_NW-1:0] ds_num;
  logic [DS_DW-1:0] ds_den;
  logic             ds_busy;
  logic             ds_done;
  logic [31:0]      ds_res;

  cpt_ram #(
    .WIDTH ($bits(cpt_row_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrow),
    .raddr (i[IW-1:0]),
    .rdata (row)
  );

  cpt_divsqrt u_ds (
    .clk       (clk),
    .rst       (rst),
    .start     (ds_start),
    .sqrt_mode (ds_sqrt),
    .num       (ds_num),
    .den       (ds_den),
    .busy      (ds_busy),
    .done      (ds_done),
    .result    (ds_res)
  );

  assign in_ready = (state == S_IDLE);

  // row lanes
  logic signed [31:0] sa [3];
  logic signed [31:0] ea [3];
  logic signed [32:0] ab [3];
  logic signed [32:0] ap [3];
  logic [1:0]         lane;

  assign sa[0] = row.sx;
  assign sa[1] = row.sy;
  assign sa[2] = row.sz;
  assign ea[0] = row.ex;
  assign ea[1] = row.ey;
  assign ea[2] = row.ez;
  assign lane  = (k >= 3'd3) ? 2'(k - 3'd3) : k[1:0];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      ab[n] = 33'($signed(ea[n])) - 33'($signed(sa[n]));
      ap[n] = 33'($signed(p[n])) - 33'($signed(sa[n]));
    end
  end

  // start match for a register word
  logic signed [32:0] dxs [3];
  logic [32:0]        dxm [3];
  logic [14:0]        msum;
  logic               comp_ok;
  logic               match;

  always_comb begin
    comp_ok = 1'b1;
    msum    = '0;
    for (int n = 0; n < 3; n++) begin
      dxs[n] = 33'($signed(sa[n])) - 33'($signed(p[n]));
      dxm[n] = mag33(dxs[n]);
      if (dxm[n] >= MATCH_COMP) begin
        comp_ok = 1'b0;
      end
      msum = msum + 15'(dxm[n][6:0] * dxm[n][6:0]);
    end
    match = comp_ok && (msum < MATCH_D2);
  end

  // age test for expire
  logic [31:0] age;
  logic        keep;
  assign age  = now_r - row.stamp;
  assign keep = (age <= 32'(max_age));

  // segment projection numerator
  logic [65:0] num;
  assign num = pos - neg;

  // shared multiplier operand select
  logic [32:0] mul_a;
  logic [32:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_APP_M: begin
        mul_b = mag33(ab[lane]);
        mul_a = (k < 3'd3) ? mag33(ab[lane]) : mag33(ap[lane]);
      end
      S_CM: begin
        mul_a = mag33(ab[lane]);
        mul_b = 33'(t);
      end
      S_DM: begin
        mul_a = (k == 3'd3) ? 33'(row.rad) : 33'(dmag[lane]);
        mul_b = mul_a;
      end
      S_PM: begin
        mul_a = 33'(dmag[lane]);
        mul_b = 33'(row.rad);
      end
      default: ;
    endcase
  end

  // point minus nearest point
  logic signed [34:0] dd [3];
  logic [34:0]        ddm [3];
  logic               outside;

  always_comb begin
    outside = 1'b0;
    for (int n = 0; n < 3; n++) begin
      dd[n]  = 35'($signed(p[n])) - 35'(cen[n]);
      ddm[n] = dd[n][34] ? 35'(-dd[n]) : 35'(dd[n]);
      if (ddm[n] >= 35'(row.rad)) begin
        outside = 1'b1;
      end
    end
  end

  // pushed component, saturated
  logic signed [34:0] psum;
  logic signed [31:0] psat;

  always_comb begin
    psum = 35'(cen[lane]) + (dneg[lane] ? -35'(ds_res) : 35'(ds_res));
    if (psum > 35'sd2147483647) begin
      psat = 32'sh7FFF_FFFF;
    end else if (psum < -35'sd2147483648) begin
      psat = 32'sh8000_0000;
    end else begin
      psat = psum[31:0];
    end
  end

  // shared unit requests
  always_comb begin
    ds_start = 1'b0;
    ds_sqrt  = 1'b0;
    ds_num   = '0;
    ds_den   = ab2;
    case (state)
      S_SEG: begin
        ds_start = (ab2 >= SEG_MIN_D2) && (neg < pos) && (num < ab2);
        ds_num   = {num, 32'b0};
      end
      S_LEN: begin
        ds_start = (d2 != '0) && (d2 < rr);
        ds_sqrt  = 1'b1;
        ds_num   = DS_NW'(d2);
      end
      S_PDIV: begin
        ds_start = 1'b1;
        ds_num   = DS_NW'(prod) + DS_NW'(len[31:1]);
        ds_den   = DS_DW'(len);
      end
      default: ;
    endcase
  end

  // RAM write port
  cpt_row_t nrow;

  always_comb begin
    nrow.sx    = p[0];
    nrow.sy    = p[1];
    nrow.sz    = p[2];
    nrow.ex    = q[0];
    nrow.ey    = q[1];
    nrow.ez    = q[2];
    nrow.rad   = rad_in;
    nrow.stamp = now_r;
    nrow.hits  = '0;
    we    = 1'b0;
    waddr = i[IW-1:0];
    wrow  = row;
    case (state)
      S_DISP: begin
        if (op == OP_REG && match) begin
          we        = 1'b1;
          wrow      = nrow;
          wrow.hits = row.hits;
        end else if (op == OP_EXPIRE && keep) begin
          we    = 1'b1;
          waddr = j[IW-1:0];
        end
      end
      S_APPEND: begin
        we    = (count < CW'(ENTRIES));
        waddr = count[IW-1:0];
        wrow  = nrow;
      end
      S_HIT: begin
        we = 1'b1;
        if (row.hits != HIT_MAX) begin
          wrow.hits = row.hits + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      max_age   <= AGE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_age <= cfg_wdata;
      end
      // a new result in S_OUT takes over the slot being drained
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= operation;
            p[0]   <= p_x;
            p[1]   <= p_y;
            p[2]   <= p_z;
            q[0]   <= q_x;
            q[1]   <= q_y;
            q[2]   <= q_z;
            rad_in <= push_radius;
            now_r  <= now_ms;
            i      <= '0;
            j      <= '0;
            mvd    <= 1'b0;
            hit_r  <= '0;
            if ((operation == OP_REG && push_radius != '0) || operation == OP_APPLY ||
                operation == OP_EXPIRE) begin
              state <= S_LOOP;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_LOOP: begin
          if (i == count) begin
            case (op)
              OP_REG:    state <= S_APPEND;
              OP_EXPIRE: begin
                count <= j;
                state <= S_OUT;
              end
              default:   state <= S_OUT;
            endcase
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_DISP;
        S_DISP: begin
          case (op)
            OP_REG: begin
              if (match) begin
                hit_r <= row.hits;
                state <= S_OUT;
              end else begin
                state <= S_NEXT;
              end
            end
            OP_EXPIRE: begin
              if (keep) begin
                j <= j + CW'(1);
              end
              state <= S_NEXT;
            end
            default: begin
              for (int n = 0; n < 3; n++) begin
                cen[n] <= 34'($signed(sa[n]));
              end
              ab2   <= '0;
              pos   <= '0;
              neg   <= '0;
              k     <= '0;
              state <= S_APP_M;
            end
          endcase
        end
        // squared length and dot product terms
        S_APP_M: state <= S_APP_A;
        S_APP_A: begin
          if (k < 3'd3) begin
            ab2 <= ab2 + prod;
          end else if (ap[lane][32] != ab[lane][32]) begin
            neg <= neg + prod;
          end else begin
            pos <= pos + prod;
          end
          k     <= k + 3'd1;
          state <= (k == 3'd5) ? S_SEG : S_APP_M;
        end
        // nearest point on the segment
        S_SEG: begin
          if ((ab2 >= SEG_MIN_D2) && (neg < pos)) begin
            if (num >= ab2) begin
              for (int n = 0; n < 3; n++) begin
                cen[n] <= 34'($signed(ea[n]));
              end
              state <= S_DCHK;
            end else begin
              state <= S_TWAIT;
            end
          end else begin
            state <= S_DCHK;
          end
        end
        S_TWAIT: begin
          if (ds_done) begin
            t     <= ds_res;
            k     <= '0;
            state <= S_CM;
          end
        end
        S_CM: state <= S_CA;
        S_CA: begin
          cen[lane] <= 34'($signed(sa[lane])) +
                       (ab[lane][32] ? -34'((prod + 66'h8000_0000) >> 32)
                                     : 34'((prod + 66'h8000_0000) >> 32));
          k     <= k + 3'd1;
          state <= (k == 3'd2) ? S_DCHK : S_CM;
        end
        // offset from the nearest point
        S_DCHK: begin
          if (outside) begin
            state <= S_NEXT;
          end else begin
            for (int n = 0; n < 3; n++) begin
              dmag[n] <= ddm[n][30:0];
              dneg[n] <= dd[n][34];
            end
            d2    <= '0;
            k     <= '0;
            state <= S_DM;
          end
        end
        S_DM: state <= S_DA;
        S_DA: begin
          if (k == 3'd3) begin
            rr    <= prod;
            state <= S_LEN;
          end else begin
            d2    <= d2 + prod;
            k     <= k + 3'd1;
            state <= S_DM;
          end
        end
        S_LEN: state <= ds_start ? S_LWAIT : S_NEXT;
        S_LWAIT: begin
          if (ds_done) begin
            len   <= ds_res;
            k     <= '0;
            state <= S_PM;
          end
        end
        // push each component out to the radius
        S_PM:   state <= S_PDIV;
        S_PDIV: state <= S_PWAIT;
        S_PWAIT: begin
          if (ds_done) begin
            p[lane] <= psat;
            k       <= k + 3'd1;
            state   <= (k == 3'd2) ? S_HIT : S_PM;
          end
        end
        S_HIT: begin
          mvd   <= 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          i     <= i + CW'(1);
          state <= S_LOOP;
        end
        S_APPEND: begin
          if (count < CW'(ENTRIES)) begin
            count <= count + CW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_x     <= (op == OP_APPLY) ? p[0] : '0;
            out_y     <= (op == OP_APPLY) ? p[1] : '0;
            out_z     <= (op == OP_APPLY) ? p[2] : '0;
            moved     <= mvd;
            hit_count <= hit_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CPT_CHECK(a_count_bound, count <= CW'(ENTRIES))
  `CPT_CHECK(a_unit_free_on_start, !(ds_start && ds_busy))
  `CPT_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== dv/tb_capsule_pushout_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capsule_pushout_table
// Self-checking bench for the capsule push-out table.
// ----------------------------------------------------------------------------
// Words go in through a valid/ready sender. Each accepted word runs through a
// local integer model of the capsule table. The model covers matching, the
// closest point on the segment, the push-out and expiry. The expected result
// is queued, and a receiver with random stalls compares each result word in
// order. The bench runs directed cases, a full table, age register sweeps, a
// backpressure burst and random phases mixing well-formed traffic with noise.
// ----------------------------------------------------------------------------
module tb_capsule_pushout_table;
  import cpt_pkg::*;

  localparam longint ONE = 65536;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_REG;
  logic signed [31:0] p_x = '0, p_y = '0, p_z = '0;
  logic signed [31:0] q_x = '0, q_y = '0, q_z = '0;
  logic [30:0]        push_radius = '0;
  logic [31:0]        now_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic               moved;
  logic [15:0]        hit_count;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] px, py, pz, qx, qy, qz;
    logic [30:0]        rad;
    logic [31:0]        now;
  } word_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               mv;
    logic [15:0]        hits;
  } pushout_t;

  // local copy of the table
  cpt_row_t    tbl [CPT_ENTRIES];
  int          n_entries;
  logic [15:0] age_limit;

  pushout_t pending_pushouts[$];
  int       mismatches;
  int       idle_max;
  int       rx_hold;
  logic [31:0] ms_clock;
  int       n_reg, n_apply, n_expire, n_other, n_moved, n_refresh, n_checked;

  capsule_pushout_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .p_x(p_x), .p_y(p_y), .p_z(p_z), .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .push_radius(push_radius), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .moved(moved), .hit_count(hit_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("FAIL capsule_pushout_table");
    $finish;
  end

  // --------------------------------------------------------------------------
  // table model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // push the point out of one capsule
  function automatic void push_through(int e, ref longint pt[3], ref logic mv);
    longint a[3], b[3], ab[3], ap[3], cen[3], d[3];
    logic [127:0] ab2, pos, neg, num, t, m;
    logic [63:0] r, d2, len, step;
    longint s;
    a = '{longint'(tbl[e].sx), longint'(tbl[e].sy), longint'(tbl[e].sz)};
    b = '{longint'(tbl[e].ex), longint'(tbl[e].ey), longint'(tbl[e].ez)};
    r = 64'(tbl[e].rad);
    ab2 = 0; pos = 0; neg = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ap[i] = pt[i] - a[i];
      ab2 += 128'(mag64(ab[i])) * 128'(mag64(ab[i]));
      if ((ap[i] < 0) != (ab[i] < 0)) neg += 128'(mag64(ap[i])) * 128'(mag64(ab[i]));
      else pos += 128'(mag64(ap[i])) * 128'(mag64(ab[i]));
      cen[i] = a[i];
    end
    // nearest point on the segment, t clamped to [0,1]
    if (ab2 >= 128'(SEG_MIN_D2) && neg < pos) begin
      num = pos - neg;
      if (num >= ab2) begin
        cen = b;
      end else begin
        t = (num << 32) / ab2;
        for (int i = 0; i < 3; i++) begin
          m = 128'(mag64(ab[i])) * t + 128'h8000_0000;
          s = longint'(m[95:32]);
          cen[i] = a[i] + (ab[i] < 0 ? -s : s);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = pt[i] - cen[i];
      if (mag64(d[i]) >= r) return;
    end
    d2 = 0;
    for (int i = 0; i < 3; i++) d2 += mag64(d[i]) * mag64(d[i]);
    if (d2 == 0 || d2 >= r * r) return;
    len = isqrt64(d2);
    for (int i = 0; i < 3; i++) begin
      step = (mag64(d[i]) * r + (len >> 1)) / len;
      s = longint'(step);
      pt[i] = sat32(cen[i] + (d[i] < 0 ? -s : s));
    end
    if (tbl[e].hits != HIT_MAX) tbl[e].hits++;
    mv = 1'b1;
  endfunction

  function automatic pushout_t predict_pushout(word_t w);
    pushout_t res;
    longint pt[3];
    longint dx, dy, dz;
    logic [63:0] mx, my, mz;
    logic mv;
    bit done;
    int j;
    cpt_row_t row;
    res = '{x: 0, y: 0, z: 0, mv: 1'b0, hits: 16'd0};
    mv = 1'b0;
    pt = '{longint'(w.px), longint'(w.py), longint'(w.pz)};
    row = '{sx: w.px, sy: w.py, sz: w.pz, ex: w.qx, ey: w.qy, ez: w.qz,
            rad: w.rad, stamp: w.now, hits: 16'd0};
    case (w.op)
      OP_REG: begin
        n_reg++;
        if (w.rad != 0) begin
          done = 0;
          for (int i = 0; i < n_entries && !done; i++) begin
            dx = longint'(tbl[i].sx) - pt[0];
            dy = longint'(tbl[i].sy) - pt[1];
            dz = longint'(tbl[i].sz) - pt[2];
            mx = mag64(dx); my = mag64(dy); mz = mag64(dz);
            if (mx < 64'(MATCH_COMP) && my < 64'(MATCH_COMP) && mz < 64'(MATCH_COMP) &&
                mx * mx + my * my + mz * mz < 64'(MATCH_D2)) begin
              res.hits = tbl[i].hits;
              row.hits = tbl[i].hits;
              tbl[i] = row;
              done = 1;
              n_refresh++;
            end
          end
          if (!done && n_entries < CPT_ENTRIES) begin
            tbl[n_entries] = row;
            n_entries++;
          end
        end
      end
      OP_APPLY: begin
        n_apply++;
        for (int i = 0; i < n_entries; i++) push_through(i, pt, mv);
        res.x = pt[0][31:0];
        res.y = pt[1][31:0];
        res.z = pt[2][31:0];
        res.mv = mv;
        if (mv) n_moved++;
      end
      OP_EXPIRE: begin
        n_expire++;
        j = 0;
        for (int i = 0; i < n_entries; i++) begin
          if (32'(w.now - tbl[i].stamp) <= 32'(age_limit)) begin
            tbl[j] = tbl[i];
            j++;
          end
        end
        n_entries = j;
      end
      default: n_other++;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // sender, receiver and checker
  // --------------------------------------------------------------------------
  task automatic send_word(word_t w);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = w.op;
    p_x = w.px; p_y = w.py; p_z = w.pz;
    q_x = w.qx; q_y = w.qy; q_z = w.qz;
    push_radius = w.rad;
    now_ms = w.now;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_pushouts.push_back(predict_pushout(w));
    @(negedge clk);
  endtask

  function automatic word_t mk(logic [1:0] op, longint px, longint py, longint pz,
                               longint qx, longint qy, longint qz, longint rad,
                               logic [31:0] now);
    word_t w;
    w.op = op;
    w.px = px[31:0]; w.py = py[31:0]; w.pz = pz[31:0];
    w.qx = qx[31:0]; w.qy = qy[31:0]; w.qz = qz[31:0];
    w.rad = rad[30:0];
    w.now = now;
    return w;
  endfunction

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_pushouts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_age(logic [15:0] age);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = age;
    @(negedge clk);
    cfg_we = 1'b0;
    age_limit = age;
    repeat (2) @(negedge clk);
  endtask

  // receiver: random stalls, long hold-off on request, checks every word
  initial begin
    int stall;
    pushout_t exp_w;
    forever begin
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, idle_max);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      n_checked++;
      if (pending_pushouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing pending");
      end else begin
        exp_w = pending_pushouts.pop_front();
        if (out_x !== exp_w.x || out_y !== exp_w.y || out_z !== exp_w.z ||
            moved !== exp_w.mv || hit_count !== exp_w.hits) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d exp (%0d %0d %0d mv %0b hits %0d) got (%0d %0d %0d mv %0b hits %0d)",
                     n_checked, exp_w.x, exp_w.y, exp_w.z, exp_w.mv, exp_w.hits,
                     out_x, out_y, out_z, moved, hit_count);
        end
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic longint near_coord();
    return longint'($urandom_range(0, 20 * ONE)) - 10 * ONE;
  endfunction

  function automatic longint jitter(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic word_t random_word();
    word_t w;
    int pick, k;
    longint sx, sy, sz;
    pick = $urandom_range(0, 99);
    ms_clock += $urandom_range(0, 12);
    w = mk(OP_REG, near_coord(), near_coord(), near_coord(),
           near_coord(), near_coord(), near_coord(),
           $urandom_range(ONE / 8, 3 * ONE), ms_clock);
    if (pick < 20) begin
      // new capsule near the origin
    end else if (pick < 35 && n_entries > 0) begin
      // refresh or near miss of a stored start
      k = $urandom_range(0, n_entries - 1);
      sx = longint'(tbl[k].sx) + jitter(70);
      sy = longint'(tbl[k].sy) + jitter(70);
      sz = longint'(tbl[k].sz) + jitter(70);
      w.px = sx[31:0]; w.py = sy[31:0]; w.pz = sz[31:0];
    end else if (pick < 65) begin
      w.op = OP_APPLY;
      if (n_entries > 0 && pick < 55) begin
        k = $urandom_range(0, n_entries - 1);
        sx = longint'(tbl[k].sx) + jitter(2 * ONE);
        sy = longint'(tbl[k].sy) + jitter(2 * ONE);
        sz = longint'(tbl[k].sz) + jitter(2 * ONE);
        w.px = sx[31:0]; w.py = sy[31:0]; w.pz = sz[31:0];
      end
    end else if (pick < 75) begin
      w.op = OP_EXPIRE;
    end else if (pick < 80) begin
      w.op = 2'd3;
    end else if (pick < 85) begin
      w.rad = 0;
    end else begin
      // noise over the full field ranges
      w.op = 2'($urandom_range(0, 3));
      w.px = $urandom(); w.py = $urandom(); w.pz = $urandom();
      w.qx = $urandom(); w.qy = $urandom(); w.qz = $urandom();
      w.rad = 31'($urandom());
      w.now = (pick < 92) ? $urandom() : ms_clock;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_ops();
    longint big;
    big = 64'sh7FFF_0000;
    idle_max = 17;
    send_word(mk(OP_APPLY, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0));            // empty table
    send_word(mk(OP_REG, 0, 0, 0, 4 * ONE, 0, 0, 0, 100));                    // zero radius
    send_word(mk(OP_REG, 0, 0, 0, 4 * ONE, 0, 0, ONE, 100));
    send_word(mk(OP_APPLY, 2 * ONE, ONE / 2, 0, 0, 0, 0, 0, 0));              // mid segment
    send_word(mk(OP_APPLY, -ONE / 2, ONE / 5, 0, 0, 0, 0, 0, 0));             // before start
    send_word(mk(OP_APPLY, 4 * ONE + ONE / 3, 0, ONE / 10, 0, 0, 0, 0, 0));   // past end
    send_word(mk(OP_APPLY, 2 * ONE, 0, 0, 0, 0, 0, 0, 0));                    // on the axis
    send_word(mk(OP_REG, 10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE, 10 * ONE,
                 2 * ONE, 110));                                              // point capsule
    send_word(mk(OP_APPLY, 10 * ONE + ONE / 2, 10 * ONE, 10 * ONE, 0, 0, 0, 0, 0));
    send_word(mk(OP_REG, 30, -30, 20, 0, 5 * ONE, 0, ONE, 150));              // refresh
    send_word(mk(OP_REG, 66, 0, 0, 0, 0, 0, ONE, 100));                       // just outside match
    send_word(mk(2'd3, -1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF, '1));           // unused code
    send_word(mk(OP_REG, big, 0, 0, big, 0, 0, 31'h7FFF_FFFF, 120));
    send_word(mk(OP_REG, -big, 0, 0, -big, 0, 0, 31'h7FFF_FFFF, 120));
    send_word(mk(OP_APPLY, 64'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));             // saturate high
    send_word(mk(OP_APPLY, -64'sh8000_0000, 0, 0, 0, 0, 0, 0, 0));            // saturate low
    send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 170));                       // age exactly limit
    send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 171));
    send_word(mk(OP_REG, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 31'h7FFF_FFFF, '1));
    send_word(mk(OP_APPLY, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0, 0, 0, 0, 0));
    send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 32'd1000));
  endtask

  task automatic test_full_table();
    idle_max = 0;
    for (int i = 0; i < CPT_ENTRIES + 3; i++)
      send_word(mk(OP_REG, i * ONE, 0, 0, i * ONE, ONE, 0, ONE / 4, 2000));
    send_word(mk(OP_APPLY, 5 * ONE, ONE / 8, 0, 0, 0, 0, 0, 0));
    send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 5000));
  endtask

  task automatic test_age_settings();
    logic [15:0] ages[3];
    logic [31:0] base;
    ages = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534))};
    idle_max = 17;
    foreach (ages[k]) begin
      write_age(ages[k]);
      base = 32'hFFFF_FFF0;
      send_word(mk(OP_REG, ONE, 0, 0, 2 * ONE, 0, 0, ONE, base));
      send_word(mk(OP_REG, 3 * ONE, 0, 0, 2 * ONE, 0, 0, ONE, base + 1));
      send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, base + ages[k] + 1));  // wraps for big ages
      send_word(mk(OP_EXPIRE, 0, 0, 0, 0, 0, 0, 0, base + ages[k] + 2));
    end
  endtask

  task automatic test_backpressure();
    idle_max = 0;
    rx_hold = 3000;
    for (int i = 0; i < 14; i++) send_word(random_word());
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [15:0] phase_age[4];
    phase_age = '{16'($urandom()), 16'd60, 16'hFFFF, 16'd0};
    foreach (phase_age[k]) begin
      write_age(phase_age[k]);
      if (k == 2) ms_clock = 32'hFFFF_FE00;
      for (int i = 0; i < 80; i++) begin
        idle_max = ((i / 20) % 2 == 1) ? 0 : 17;
        send_word(random_word());
      end
    end
  endtask

  initial begin
    n_entries = 0;
    age_limit = AGE_RESET;
    mismatches = 0;
    idle_max = 17;
    rx_hold = 0;
    ms_clock = 32'd10000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_full_table();
    test_age_settings();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (200) @(negedge clk);

    $display("Covered %0d register, %0d apply, %0d expire, %0d unused-code words;",
             n_reg, n_apply, n_expire, n_other);
    $display("%0d applies moved the point, %0d refreshes, %0d result words, %0d mismatches",
             n_moved, n_refresh, n_checked, mismatches);
    if (mismatches == 0 && pending_pushouts.size() == 0) begin
      $display("PASS capsule_pushout_table");
    end else begin
      $display("FAIL capsule_pushout_table");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/cpt_pkg.sv
design/cpt_ram.sv
design/cpt_divsqrt.sv
design/capsule_pushout_table.sv
dv/tb_capsule_pushout_table.sv
